// ===== design/multi_pattern_glob_matcher_assert.svh =====
// Assertion helpers used by the matcher RTL.
`ifndef MULTI_PATTERN_GLOB_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_GLOB_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge outside reset.
`define MPGM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge outside reset.
`define MPGM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mpgm_pkg.sv =====
`default_nettype none
package mpgm_pkg;

    localparam int Patterns    = 64;
    localparam int Capabilities = 64;
    localparam int PatternLen  = 64;
    localparam int PIdxW       = $clog2(Patterns);
    localparam int LenW        = $clog2(PatternLen + 1);
    localparam int TagW        = 6;
    localparam int CapW        = 64;
    localparam int PosW        = 6;
    localparam int CntW        = $clog2(Patterns + 1);
    localparam int CloseSteps  = $clog2(PatternLen + 1);

    localparam logic [7:0] StarByte = 8'h2A;

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_HEADER = 2'd1,
        OP_NAME   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef logic [PatternLen:0]     t_act;
    typedef logic [PatternLen*8-1:0] t_row;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Extends active positions across runs of stars by span doubling.
    function automatic t_act close_stars(input t_act a, input logic [PatternLen-1:0] s);
        t_act r;
        t_act p;
        r = a;
        p = {1'b0, s};
        for (int k = 0; k < CloseSteps; k++) begin
            r = r | ((r & p) << (1 << k));
            p = p & (p >> (1 << k));
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/multi_pattern_glob_matcher.sv =====
`default_nettype none
// Multi-pattern glob matcher. Patterns are loaded with char and header
// transactions, then name bytes stream in. Every transaction is offered on
// start and taken when busy is low. Char, header and clear transactions never
// raise busy. A name byte makes one pass over the pattern table, one pattern
// per cycle through the pattern, header and active-position memories, and
// keeps the block busy through a read of each pattern, the write-back of the
// last pattern, a drain step and the step that closes the byte.
// On the last byte of a name one result transaction appears on o_valid for
// exactly one cycle with the capability mask of this name and the updated
// sticky findings; the receiver cannot stall it, so it must take it then.
// There is no clearing pass after reset.
module multi_pattern_glob_matcher (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [5:0]                i_pattern_index,
    input  wire logic [5:0]                i_char_position,
    input  wire logic [7:0]                i_char_value,
    input  wire logic [6:0]                i_pattern_length,
    input  wire logic [5:0]                i_capability_tag,
    input  wire logic                      i_pattern_valid,
    input  wire logic                      i_name_last,
    output logic                           o_valid,
    output logic [63:0]                    o_name_match_mask,
    output logic [63:0]                    o_findings_mask
);

    localparam int PL = mpgm_pkg::PatternLen;

    // Pattern bytes: one row per pattern, written a byte at a time.
    mpgm_pkg::t_row r_pb_mem [mpgm_pkg::Patterns];
    // Header data: {tag, saturated length}. Valid marks live in flops.
    logic [mpgm_pkg::TagW+mpgm_pkg::LenW-1:0] r_hdr_mem [mpgm_pkg::Patterns];
    // Active positions for each pattern during a name.
    mpgm_pkg::t_act r_act_mem [mpgm_pkg::Patterns];

    logic [mpgm_pkg::Patterns-1:0] r_hdr_vld;
    logic [mpgm_pkg::Patterns-1:0] r_act_ok;

    mpgm_pkg::t_state r_state, n_state;
    logic [mpgm_pkg::CntW-1:0]  r_rd_cnt, n_rd_cnt;
    logic                       r_wb_vld, n_wb_vld;
    logic [mpgm_pkg::PIdxW-1:0] r_wb_idx;
    logic [7:0]                 r_char;
    logic                       r_last;
    logic                       r_in_name;
    logic [63:0]                r_mask;
    logic [63:0]                r_findings;

    mpgm_pkg::t_row r_pb_rd;
    logic [mpgm_pkg::TagW+mpgm_pkg::LenW-1:0] r_hdr_rd;
    mpgm_pkg::t_act r_act_rd;

    logic accept;
    logic rd_en;
    logic [mpgm_pkg::PIdxW-1:0] rd_idx;
    logic [mpgm_pkg::PIdxW-1:0] wr_idx;
    logic [mpgm_pkg::LenW-1:0]  sat_len;
    logic [mpgm_pkg::LenW-1:0]  wb_len;
    logic [mpgm_pkg::TagW-1:0]  wb_tag;
    logic [PL-1:0]              star_vec;
    mpgm_pkg::t_act             cur_act, adv_act, new_act;
    logic [7:0]                 name_fc;
    logic                       hit;

    assign accept = start && !busy;
    assign busy   = (r_state != mpgm_pkg::ST_IDLE);
    assign wr_idx = i_pattern_index[mpgm_pkg::PIdxW-1:0];
    assign rd_idx = r_rd_cnt[mpgm_pkg::PIdxW-1:0];
    assign rd_en  = (r_state == mpgm_pkg::ST_SCAN)
                    && (r_rd_cnt < mpgm_pkg::CntW'(mpgm_pkg::Patterns));
    assign sat_len = (i_pattern_length > 7'(PL)) ? mpgm_pkg::LenW'(PL)
                                                 : mpgm_pkg::LenW'(i_pattern_length);

    // Sequencer for the pattern pass of one name byte.
    always_comb begin
        n_state  = r_state;
        n_rd_cnt = r_rd_cnt;
        n_wb_vld = rd_en;
        case (r_state)
            mpgm_pkg::ST_IDLE: begin
                if (accept && (i_opcode == mpgm_pkg::OP_NAME)) begin
                    n_state  = mpgm_pkg::ST_SCAN;
                    n_rd_cnt = '0;
                end
            end
            mpgm_pkg::ST_SCAN: begin
                if (rd_en) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end else if (!r_wb_vld) begin
                    n_state = mpgm_pkg::ST_DONE;
                end
            end
            mpgm_pkg::ST_DONE: begin
                n_state = mpgm_pkg::ST_IDLE;
            end
            default: begin
                n_state = mpgm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mpgm_pkg::ST_IDLE;
            r_rd_cnt <= '0;
            r_wb_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_cnt <= n_rd_cnt;
            r_wb_vld <= n_wb_vld;
        end
    end

    // Memories: writes from load transactions or write-back, registered reads.
    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == mpgm_pkg::OP_CHAR)
            && ({1'b0, i_char_position} < 7'(PL))) begin
            r_pb_mem[wr_idx][i_char_position*8 +: 8] <= i_char_value;
        end
        if (accept && (i_opcode == mpgm_pkg::OP_HEADER)) begin
            r_hdr_mem[wr_idx] <= {i_capability_tag, sat_len};
        end
        if (r_wb_vld) begin
            r_act_mem[r_wb_idx] <= new_act;
        end
        if (rd_en) begin
            r_pb_rd  <= r_pb_mem[rd_idx];
            r_hdr_rd <= r_hdr_mem[rd_idx];
            r_act_rd <= r_act_mem[rd_idx];
            r_wb_idx <= rd_idx;
        end
    end

    // Advance one pattern by the current name byte.
    assign wb_len  = r_hdr_rd[mpgm_pkg::LenW-1:0];
    assign wb_tag  = r_hdr_rd[mpgm_pkg::TagW+mpgm_pkg::LenW-1:mpgm_pkg::LenW];
    assign name_fc = mpgm_pkg::fold_case(r_char);

    always_comb begin
        for (int j = 0; j < PL; j++) begin
            star_vec[j] = (mpgm_pkg::LenW'(j) < wb_len)
                          && (r_pb_rd[j*8 +: 8] == mpgm_pkg::StarByte);
        end
        if (r_in_name) begin
            cur_act = r_act_ok[r_wb_idx] ? r_act_rd : '0;
        end else begin
            cur_act = mpgm_pkg::close_stars(mpgm_pkg::t_act'(1), star_vec);
        end
        adv_act = '0;
        for (int j = 0; j < PL; j++) begin
            if (cur_act[j] && (mpgm_pkg::LenW'(j) < wb_len)) begin
                if (r_pb_rd[j*8 +: 8] == mpgm_pkg::StarByte) begin
                    adv_act[j] = 1'b1;
                end else if (mpgm_pkg::fold_case(r_pb_rd[j*8 +: 8]) == name_fc) begin
                    adv_act[j+1] = 1'b1;
                end
            end
        end
        new_act = mpgm_pkg::close_stars(adv_act, star_vec);
        hit = r_hdr_vld[r_wb_idx] && ({1'b0, wb_tag} < 7'(mpgm_pkg::Capabilities))
              && new_act[wb_len];
    end

    // Control flags, name tracking, mask and findings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_vld  <= '0;
            r_act_ok   <= '0;
            r_in_name  <= 1'b0;
            r_findings <= '0;
            r_mask     <= '0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (accept) begin
                case (i_opcode)
                    mpgm_pkg::OP_HEADER: begin
                        r_hdr_vld[wr_idx] <= i_pattern_valid;
                        r_act_ok[wr_idx]  <= 1'b0;
                    end
                    mpgm_pkg::OP_CLEAR: begin
                        r_findings <= '0;
                    end
                    mpgm_pkg::OP_NAME: begin
                        r_mask <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_wb_vld) begin
                r_act_ok[r_wb_idx] <= 1'b1;
                if (hit) begin
                    r_mask[wb_tag] <= 1'b1;
                end
            end
            if (r_state == mpgm_pkg::ST_DONE) begin
                r_in_name <= !r_last;
                if (r_last) begin
                    r_findings <= r_findings | r_mask;
                    o_valid    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == mpgm_pkg::OP_NAME)) begin
            r_char <= i_char_value;
            r_last <= i_name_last;
        end
        if ((r_state == mpgm_pkg::ST_DONE) && r_last) begin
            o_name_match_mask <= r_mask;
            o_findings_mask   <= r_findings | r_mask;
        end
    end

`include "multi_pattern_glob_matcher_assert.svh"

    `MPGM_ASSERT_NEXT(a_name_busy, accept && (i_opcode == mpgm_pkg::OP_NAME), busy, "name byte did not start a pass")
    `MPGM_ASSERT_NOW(a_find_cover, o_valid, (o_findings_mask & o_name_match_mask) == o_name_match_mask, "findings lost mask bits")
    `MPGM_ASSERT_NOW(a_wb_scan, r_wb_vld, r_state == mpgm_pkg::ST_SCAN, "write-back outside a pass")

endmodule
`default_nettype wire
